// File: hdl/hetdr_pkg.sv
// Shared constants, codes and types for the hashed entry table.
// No dependencies; every other file of the block but hetdr_ram.sv imports this package.
package hetdr_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int SCORE_BITS_DEF  = 16;

  localparam int KEY_W      = 64;
  localparam int HALF_W     = 32;
  localparam int DEPTH_W    = 8;
  localparam int BOUND_W    = 2;
  localparam int MOVE_W     = 16;
  localparam int SCORE_W    = 16;
  localparam int PLY_W      = 8;
  localparam int SIZE_W     = 17;
  localparam int THR_W      = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 17'd65536;
  localparam logic [THR_W-1:0]  MATE_THR_RST   = 15'd31744;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATE_THRESHOLD = 8'd1;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd1;

  localparam logic MODE_SAVE  = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                      mode;
    logic [KEY_W-1:0]          search_key;
    logic [DEPTH_W-1:0]        new_depth;
    logic [BOUND_W-1:0]        new_bound;
    logic [MOVE_W-1:0]         new_move;
    logic signed [SCORE_W-1:0] new_score;
    logic [PLY_W-1:0]          ply;
  } req_item_t;

endpackage

// File: hdl/hetdr_if.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on hetdr_pkg for field widths.
interface hetdr_req_if import hetdr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [KEY_W-1:0]          search_key;
  logic [DEPTH_W-1:0]        new_depth;
  logic [BOUND_W-1:0]        new_bound;
  logic [MOVE_W-1:0]         new_move;
  logic signed [SCORE_W-1:0] new_score;
  logic [PLY_W-1:0]          ply;

  modport source (output valid, mode, search_key, new_depth, new_bound, new_move,
                  new_score, ply, input ready);
  modport sink   (input valid, mode, search_key, new_depth, new_bound, new_move,
                  new_score, ply, output ready);
endinterface

interface hetdr_rsp_if import hetdr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      written;
  logic                      key_match;
  logic [KEY_W-1:0]          slot_key;
  logic [DEPTH_W-1:0]        slot_depth;
  logic [BOUND_W-1:0]        slot_bound;
  logic [MOVE_W-1:0]         slot_move;
  logic signed [SCORE_W-1:0] slot_score;

  modport source (output valid, written, key_match, slot_key, slot_depth, slot_bound,
                  slot_move, slot_score, input ready);
  modport sink   (input valid, written, key_match, slot_key, slot_depth, slot_bound,
                  slot_move, slot_score, output ready);
endinterface

interface hetdr_cfg_if import hetdr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/hetdr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hetdr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/hashed_entry_table_depth_replace_top.sv
// Hashed entry table top level: slot hashing, depth-preferred replacement, mate scores.
// Depends on hetdr_pkg, the interfaces in hetdr_if.sv and hetdr_ram.
//
//   channel  dir  handshake    carries
//   req      in   valid/ready  mode, search_key, new_depth/bound/move/score, ply
//   rsp      out  valid/ready  written, key_match, slot_key/depth/bound/move/score
//   cfg      in   valid/ready  index, data (table_size, mate_threshold)
//
// A request runs in order: the accept cycle registers the two 32x17 slot products,
// the next adds them and issues the table read, ST_UPDATE takes the registered read
// data, writes back and loads the response register. A new request is accepted in
// the cycle after that, so no request is taken while another is in flight, as set by
// the product register and the registered read of the table memories.
// After reset a clearing pass writes zero to all TABLE_DEPTH entries, one per cycle;
// no request is accepted until it ends. A stalled response holds the update stage.
module hashed_entry_table_depth_replace_top
  import hetdr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SCORE_BITS  = SCORE_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  hetdr_req_if.sink   req,
  hetdr_rsp_if.source rsp,
  hetdr_cfg_if.sink   cfg
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CMP_W  = (SIZE_W > IDX_W + 1) ? SIZE_W : IDX_W + 1;
  localparam int PROD_W = HALF_W + SIZE_W;
  localparam int PAY_W  = DEPTH_W + BOUND_W + MOVE_W + SCORE_BITS;
  localparam int EXT_W  = SCORE_BITS + PLY_W + 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic signed [EXT_W-1:0] SMAX =
    EXT_W'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SMIN   = -SMAX - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] S16MAX =
    EXT_W'((64'sd1 <<< (SCORE_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] S16MIN = -S16MAX - EXT_W'(1);

  function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve > CMP_W'(TABLE_DEPTH)) begin
      return SIZE_W'(TABLE_DEPTH);
    end
    return v;
  endfunction

  function automatic logic signed [EXT_W-1:0] clip(input logic signed [EXT_W-1:0] v,
                                                   input logic signed [EXT_W-1:0] lo,
                                                   input logic signed [EXT_W-1:0] hi);
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Configuration
  logic [SIZE_W-1:0] size;
  logic [THR_W-1:0]  thr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= fit_size(TABLE_SIZE_RST);
      thr  <= MATE_THR_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_TABLE_SIZE: begin
          size <= fit_size(cfg.data[SIZE_W-1:0]);
        end
        REG_MATE_THRESHOLD: begin
          thr <= cfg.data[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Control
  state_t            state, state_next;
  logic [IDX_W-1:0]  clr_addr;
  logic              load;
  logic              rd_en;
  logic              req_take;

  req_item_t         item;
  logic [PROD_W-1:0] prod_hi;
  logic [SIZE_W-1:0] prod_lo_top;
  logic [KEY_W-1:0]  slot_sum;
  logic [IDX_W-1:0]  slot_calc;
  logic [IDX_W-1:0]  slot;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:   if (req.valid) state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_UPDATE;
      ST_UPDATE: if (load) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    rd_en     = (state == ST_INDEX);
    load      = (state == ST_UPDATE) && (!rsp.valid || rsp.ready);
  end

  assign req_take = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
    end
  end

  // Slot index: high bits of key * size, in two 32x17 halves
  always_ff @(posedge clk) begin
    if (req_take) begin
      item.mode       <= req.mode;
      item.search_key <= req.search_key;
      item.new_depth  <= req.new_depth;
      item.new_bound  <= req.new_bound;
      item.new_move   <= req.new_move;
      item.new_score  <= req.new_score;
      item.ply        <= req.ply;
      prod_hi         <= PROD_W'(req.search_key[KEY_W-1:HALF_W]) * PROD_W'(size);
      prod_lo_top     <= SIZE_W'((PROD_W'(req.search_key[HALF_W-1:0]) * PROD_W'(size))
                                 >> HALF_W);
    end
    if (rd_en) begin
      slot <= slot_calc;
    end
  end

  assign slot_sum  = KEY_W'(prod_hi) + KEY_W'(prod_lo_top);
  assign slot_calc = slot_sum[HALF_W +: IDX_W];

  // Table memories
  logic                  key_we;
  logic [IDX_W-1:0]      key_waddr;
  logic [KEY_W-1:0]      key_wdata;
  logic [PAY_W-1:0]      pay_wdata;
  logic [KEY_W-1:0]      key_rd;
  logic [PAY_W-1:0]      pay_rd;

  hetdr_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (rd_en),
    .raddr (slot_calc),
    .rdata (key_rd)
  );

  hetdr_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (pay_wdata),
    .re    (rd_en),
    .raddr (slot_calc),
    .rdata (pay_rd)
  );

  // Update
  logic [DEPTH_W-1:0]         st_depth;
  logic [BOUND_W-1:0]         st_bound;
  logic [MOVE_W-1:0]          st_move;
  logic signed [EXT_W-1:0]    st_score;
  logic signed [EXT_W-1:0]    thr_s;
  logic signed [EXT_W-1:0]    ply_s;
  logic signed [EXT_W-1:0]    save_in;
  logic signed [EXT_W-1:0]    save_adj;
  logic signed [EXT_W-1:0]    save_s;
  logic signed [EXT_W-1:0]    probe_adj;
  logic signed [EXT_W-1:0]    probe_s;
  logic signed [EXT_W-1:0]    shown;
  logic                       match;
  logic                       replace;
  logic [MOVE_W-1:0]          move_next;

  always_comb begin
    st_depth = pay_rd[PAY_W-1 -: DEPTH_W];
    st_bound = pay_rd[MOVE_W + SCORE_BITS +: BOUND_W];
    st_move  = pay_rd[SCORE_BITS +: MOVE_W];
    st_score = EXT_W'($signed(pay_rd[SCORE_BITS-1:0]));
    thr_s    = $signed(EXT_W'(thr));
    ply_s    = $signed(EXT_W'(item.ply));

    match   = (key_rd == item.search_key);
    replace = (item.mode == MODE_SAVE) &&
              (!match || item.new_depth >= st_depth || item.new_bound == BOUND_EXACT);

    // Save: clamp to the stored range, push mate scores away from zero by ply
    save_in = clip(EXT_W'($signed(item.new_score)), SMIN, SMAX);
    priority if (save_in >= thr_s) begin
      save_adj = save_in + ply_s;
    end else if (save_in <= -thr_s) begin
      save_adj = save_in - ply_s;
    end else begin
      save_adj = save_in;
    end
    save_s = clip(save_adj, SMIN, SMAX);

    // Probe: pull mate scores back toward zero by ply
    priority if (st_score >= thr_s) begin
      probe_adj = st_score - ply_s;
    end else if (st_score <= -thr_s) begin
      probe_adj = st_score + ply_s;
    end else begin
      probe_adj = st_score;
    end
    probe_s = clip(probe_adj, SMIN, SMAX);

    move_next = (item.new_move != '0) ? item.new_move : st_move;

    if (item.mode == MODE_PROBE) begin
      shown = clip(probe_s, S16MIN, S16MAX);
    end else if (replace) begin
      shown = clip(save_s, S16MIN, S16MAX);
    end else begin
      shown = clip(st_score, S16MIN, S16MAX);
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      key_we    = 1'b1;
      key_waddr = clr_addr;
      key_wdata = '0;
      pay_wdata = '0;
    end else begin
      key_we    = load && replace;
      key_waddr = slot;
      key_wdata = item.search_key;
      pay_wdata = {item.new_depth, item.new_bound, move_next, save_s[SCORE_BITS-1:0]};
    end
  end

  // Response register
  logic rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.written    <= replace;
      rsp.key_match  <= match;
      rsp.slot_key   <= replace ? item.search_key : key_rd;
      rsp.slot_depth <= replace ? item.new_depth : st_depth;
      rsp.slot_bound <= replace ? item.new_bound : st_bound;
      rsp.slot_move  <= replace ? move_next : st_move;
      rsp.slot_score <= shown[SCORE_W-1:0];
    end
  end

  assign rsp.valid = rsp_valid;

  // Checks
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req.ready)
    else $error("request taken during clearing pass");

  // a zero table size maps every key to slot zero
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_INDEX |-> (slot_calc == '0) || (CMP_W'(slot_calc) < CMP_W'(size)))
    else $error("slot index outside table size");

  a_probe_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE && item.mode == MODE_PROBE |-> !key_we)
    else $error("probe wrote the table");

  a_rsp_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_UPDATE)
    else $error("response raised outside update");

  a_written_key: assert property (@(posedge clk) disable iff (rst)
    load && replace |=> rsp.written && rsp.slot_key == $past(item.search_key))
    else $error("replaced slot reports wrong key");

endmodule

// File: sim/entry_table_checker.sv
// Watches the request, response and register-write channels of the hashed entry table,
// predicts every response from its own table copy and compares field by field.
// Depends on hetdr_pkg and the channel interfaces in hetdr_if.sv.
`timescale 1ns / 1ps

module entry_table_checker
  import hetdr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  hetdr_req_if  req,
  hetdr_rsp_if  rsp,
  hetdr_cfg_if  cfg,
  output int    fail_count,
  output int    open_count
);

  typedef struct packed {
    logic                      written;
    logic                      key_match;
    logic [KEY_W-1:0]          slot_key;
    logic [DEPTH_W-1:0]        slot_depth;
    logic [BOUND_W-1:0]        slot_bound;
    logic [MOVE_W-1:0]         slot_move;
    logic signed [SCORE_W-1:0] slot_score;
  } slot_view_t;

  // Shadow copy of the table; zero matches the clearing pass after reset.
  bit [KEY_W-1:0]          key_mem   [TABLE_DEPTH_DEF];
  bit [DEPTH_W-1:0]        depth_mem [TABLE_DEPTH_DEF];
  bit [BOUND_W-1:0]        bound_mem [TABLE_DEPTH_DEF];
  bit [MOVE_W-1:0]         move_mem  [TABLE_DEPTH_DEF];
  bit signed [SCORE_W-1:0] score_mem [TABLE_DEPTH_DEF];

  logic [SIZE_W-1:0] size_cfg;
  logic [THR_W-1:0]  thr_cfg;
  slot_view_t        views_due[$];

  function automatic logic signed [SCORE_W-1:0] clamp_score(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Slot is the high half of key * entries in use.
  function automatic int slot_index(logic [KEY_W-1:0] key);
    logic [SIZE_W-1:0] entries;
    logic [127:0]      prod;
    entries = (size_cfg > SIZE_W'(TABLE_DEPTH_DEF)) ? SIZE_W'(TABLE_DEPTH_DEF) : size_cfg;
    prod = {64'd0, key} * {111'd0, entries};
    return int'(prod[127:64]);
  endfunction

  function automatic slot_view_t table_access(req_item_t r);
    slot_view_t v;
    int         slot;
    int         s;
    int         thr;
    int         p;
    logic       hit;
    slot = slot_index(r.search_key);
    thr  = int'(thr_cfg);
    p    = int'(r.ply);
    hit  = (key_mem[slot] == r.search_key);
    v.written   = 1'b0;
    v.key_match = hit;
    if (r.mode == MODE_SAVE) begin
      if (!hit || r.new_depth >= depth_mem[slot] || r.new_bound == BOUND_EXACT) begin
        s = int'(r.new_score);
        // push mate scores away from zero by ply; zero counts as positive
        if (s >= thr) s = s + p;
        else if (s <= -thr) s = s - p;
        key_mem[slot]   = r.search_key;
        depth_mem[slot] = r.new_depth;
        bound_mem[slot] = r.new_bound;
        if (r.new_move != '0) move_mem[slot] = r.new_move;
        score_mem[slot] = clamp_score(s);
        v.written = 1'b1;
      end
      v.slot_score = score_mem[slot];
    end else begin
      s = int'(score_mem[slot]);
      if (s >= thr) s = s - p;
      else if (s <= -thr) s = s + p;
      v.slot_score = clamp_score(s);
    end
    v.slot_key   = key_mem[slot];
    v.slot_depth = depth_mem[slot];
    v.slot_bound = bound_mem[slot];
    v.slot_move  = move_mem[slot];
    return v;
  endfunction

  function automatic void note_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    slot_view_t want;
    req_item_t  r;
    if (rst) begin
      size_cfg = TABLE_SIZE_RST;
      thr_cfg  = MATE_THR_RST;
      views_due.delete();
      fail_count = 0;
      open_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TABLE_SIZE:     size_cfg = cfg.data[SIZE_W-1:0];
          REG_MATE_THRESHOLD: thr_cfg  = cfg.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        r = '{mode: req.mode, search_key: req.search_key, new_depth: req.new_depth,
              new_bound: req.new_bound, new_move: req.new_move,
              new_score: req.new_score, ply: req.ply};
        views_due.push_back(table_access(r));
      end
      if (rsp.valid && rsp.ready) begin
        if (views_due.size() == 0) begin
          fail_count++;
          $display("%0t: response with no request outstanding, expected none actual key %0h",
                   $time, rsp.slot_key);
        end else begin
          want = views_due.pop_front();
          note_field("written",    64'(want.written),    64'(rsp.written));
          note_field("key_match",  64'(want.key_match),  64'(rsp.key_match));
          note_field("slot_key",   want.slot_key,        rsp.slot_key);
          note_field("slot_depth", 64'(want.slot_depth), 64'(rsp.slot_depth));
          note_field("slot_bound", 64'(want.slot_bound), 64'(rsp.slot_bound));
          note_field("slot_move",  64'(want.slot_move),  64'(rsp.slot_move));
          note_field("slot_score", 64'(want.slot_score), 64'(rsp.slot_score));
        end
      end
      open_count <= views_due.size();
    end
  end

endmodule

// File: sim/tb_hashed_entry_table_depth_replace_top.sv
// Testbench top for the hashed entry table: clock, reset, request and register stimulus,
// random response back-pressure and the verdict. Checking lives in entry_table_checker.
// Depends on hetdr_pkg, hetdr_if.sv, the block's RTL and entry_table_checker.
`timescale 1ns / 1ps

module tb_hashed_entry_table_depth_replace_top;
  import hetdr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 166;
  localparam int PHASES      = 8;

  localparam logic [BOUND_W-1:0]   BOUND_NONE  = 2'd0;
  localparam logic [BOUND_W-1:0]   BOUND_LOWER = 2'd2;
  localparam logic [BOUND_W-1:0]   BOUND_UPPER = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hff;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   open_count;
  int   cycle_count = 0;
  int   gap_odds    = 0;
  int   stall_odds  = 0;
  int   cur_thr     = 31744;
  logic [KEY_W-1:0] key_pool [16];

  hetdr_req_if req_ch ();
  hetdr_rsp_if rsp_ch ();
  hetdr_cfg_if cfg_ch ();

  hashed_entry_table_depth_replace_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  entry_table_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Response back-pressure: bursts of low ready.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
          stall_left = $urandom_range(1, 15);
      end
    end
  end

  function automatic req_item_t request_of(logic m, logic [KEY_W-1:0] k,
                                           logic [DEPTH_W-1:0] d, logic [BOUND_W-1:0] b,
                                           logic [MOVE_W-1:0] mv, int sc,
                                           logic [PLY_W-1:0] p);
    req_item_t r;
    r.mode       = m;
    r.search_key = k;
    r.new_depth  = d;
    r.new_bound  = b;
    r.new_move   = mv;
    r.new_score  = 16'(sc);
    r.ply        = p;
    return r;
  endfunction

  // Mostly keys from a small pool so saves and probes hit earlier entries;
  // scores cluster around the mate threshold on both sides.
  function automatic req_item_t random_request();
    req_item_t                 r;
    logic signed [SCORE_W-1:0] raw;
    int                        v;
    r.mode       = 1'($urandom_range(0, 1));
    r.search_key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 15)]
                                              : {$urandom, $urandom};
    r.new_depth  = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    r.new_bound  = 2'($urandom);
    r.new_move   = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom);
    r.ply        = ($urandom_range(0, 7) == 0) ? '0 : 8'($urandom);
    raw = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'(raw);
      3:       v = $urandom_range(0, 1) ? 32767 : -32768;
      4, 5, 6: v = cur_thr + int'($urandom_range(0, 8)) - 4;
      7, 8:    v = -cur_thr + int'($urandom_range(0, 8)) - 4;
      default: v = int'($urandom_range(0, 4)) - 2;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    r.new_score = 16'(v);
    return r;
  endfunction

  task automatic issue(input req_item_t r);
    int n;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      n = $urandom_range(1, 15);
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      = 1'b1;
    req_ch.mode       = r.mode;
    req_ch.search_key = r.search_key;
    req_ch.new_depth  = r.new_depth;
    req_ch.new_bound  = r.new_bound;
    req_ch.new_move   = r.new_move;
    req_ch.new_score  = r.new_score;
    req_ch.ply        = r.ply;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and hold until every response is back.
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (open_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    int size_sel;
    int thr_sel;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_SAVE;
    req_ch.search_key = '0;
    req_ch.new_depth  = '0;
    req_ch.new_bound  = BOUND_NONE;
    req_ch.new_move   = '0;
    req_ch.new_score  = '0;
    req_ch.ply        = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_TABLE_SIZE;
    cfg_ch.data       = '0;

    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    // neighbors differing in low bits land in the same slot
    for (int i = 2; i < 16; i += 2) key_pool[i + 1] = key_pool[i] ^ 64'($urandom_range(1, 255));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    stall_odds = 3;
    issue(request_of(MODE_PROBE, '0, 8'd0, BOUND_NONE, 16'd0, 0, 8'd0));
    issue(request_of(MODE_SAVE, '1, 8'd255, BOUND_EXACT, 16'hffff, 32767, 8'd255));
    issue(request_of(MODE_PROBE, '1, 8'd0, BOUND_NONE, 16'd0, 0, 8'd255));
    // shallower, not exact: slot kept
    issue(request_of(MODE_SAVE, '1, 8'd0, BOUND_LOWER, 16'd0, -32768, 8'd255));
    // exact bound replaces anyway; zero move keeps the old one
    issue(request_of(MODE_SAVE, '1, 8'd0, BOUND_EXACT, 16'd0, -32768, 8'd255));
    issue(request_of(MODE_PROBE, '1, 8'd0, BOUND_NONE, 16'd0, 0, 8'd0));
    issue(request_of(MODE_SAVE, 64'h8000_0000_0000_0000, 8'd10, BOUND_UPPER, 16'd1, 0, 8'd7));
    // other key, same slot: replaces despite smaller depth
    issue(request_of(MODE_SAVE, 64'h8000_0000_0000_0001, 8'd3, BOUND_LOWER, 16'd0, 31744, 8'd7));
    issue(request_of(MODE_SAVE, 64'h8000_0000_0000_0001, 8'd2, BOUND_NONE, 16'h1234,
                     -31744, 8'd7));
    issue(request_of(MODE_PROBE, 64'h8000_0000_0000_0000, 8'd0, BOUND_NONE, 16'd0, 0, 8'd7));
    issue(request_of(MODE_PROBE, 64'h8000_0000_0000_0001, 8'd0, BOUND_NONE, 16'd0, 0, 8'd9));
    settle();

    // writes to unknown indexes change nothing
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '1);
    issue(request_of(MODE_PROBE, '1, 8'd0, BOUND_NONE, 16'd0, 0, 8'd1));
    settle();

    // zero table size maps everything to slot zero; zero threshold makes all scores mate
    write_reg(REG_TABLE_SIZE, '0);
    write_reg(REG_MATE_THRESHOLD, '0);
    cur_thr = 0;
    issue(request_of(MODE_SAVE, 64'h0123_4567_89ab_cdef, 8'd5, BOUND_UPPER, 16'h00ff, 0, 8'd5));
    issue(request_of(MODE_PROBE, 64'h0123_4567_89ab_cdef, 8'd0, BOUND_NONE, 16'd0, 0, 8'd5));
    issue(request_of(MODE_SAVE, 64'hfedc_ba98_7654_3210, 8'd5, BOUND_LOWER, 16'd0, -1, 8'd5));
    issue(request_of(MODE_PROBE, 64'hfedc_ba98_7654_3210, 8'd0, BOUND_NONE, 16'd0, 0, 8'd200));
    settle();

    // oversized table is clamped; top threshold with saturating scores
    write_reg(REG_TABLE_SIZE, '1);
    write_reg(REG_MATE_THRESHOLD, 17'h07fff);
    cur_thr = 32767;
    issue(request_of(MODE_SAVE, '1, 8'd1, BOUND_EXACT, 16'h8000, 32767, 8'd1));
    issue(request_of(MODE_SAVE, 64'h0000_ffff_0000_0000, 8'd0, BOUND_EXACT, 16'h7fff,
                     -32767, 8'd1));
    issue(request_of(MODE_SAVE, 64'h0000_ffff_0000_0000, 8'd0, BOUND_EXACT, 16'd0,
                     -32768, 8'd200));
    issue(request_of(MODE_PROBE, 64'h0000_ffff_0000_0000, 8'd0, BOUND_NONE, 16'd0, 0, 8'd255));
    issue(request_of(MODE_PROBE, '1, 8'd0, BOUND_NONE, 16'd0, 0, 8'd3));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin size_sel = 65536; thr_sel = 31744; gap_odds = 4; stall_odds = 4; end
        1: begin size_sel = 1;     thr_sel = 0;     gap_odds = 0; stall_odds = 3; end
        2: begin size_sel = 0;     thr_sel = 32767; gap_odds = 3; stall_odds = 0; end
        3: begin size_sel = 131071; thr_sel = 100;  gap_odds = 6; stall_odds = 6; end
        4: begin size_sel = 16;    thr_sel = 31744; gap_odds = 2; stall_odds = 2; end
        5: begin
          size_sel = $urandom_range(2, 4096);
          thr_sel  = $urandom_range(0, 32767);
          gap_odds = 5;
          stall_odds = 5;
        end
        6: begin size_sel = 65535; thr_sel = 1;     gap_odds = 4; stall_odds = 4; end
        default: begin size_sel = 65536; thr_sel = 31744; gap_odds = 0; stall_odds = 0; end
      endcase
      settle();
      write_reg(REG_TABLE_SIZE, 17'(size_sel));
      // upper data bits are outside the threshold field and must be dropped
      write_reg(REG_MATE_THRESHOLD, {2'($urandom), 15'(thr_sel)});
      cur_thr = thr_sel;
      repeat (PHASE_ITEMS) begin
        if (ph != PHASES - 1 && $urandom_range(0, 59) == 0) settle();
        issue(random_request());
      end
    end

    settle();
    repeat (12) @(negedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
